>>> sv/lis_length_and_count_top_defines.svh
// Assertion macros shared by the RTL of the subsequence counter.
// In synthesis the macros expand to nothing.
`ifndef LIS_LENGTH_AND_COUNT_TOP_DEFINES_SVH
`define LIS_LENGTH_AND_COUNT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is high.
`define LIS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset.
`define LIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LIS_ASSERT(lbl, clk, rst, prop, msg)
`define LIS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> sv/lis_pkg.sv
`timescale 1ns / 1ps

package lis_pkg;

  // Tree geometry.
  localparam int unsigned LEAVES = 1024;
  localparam int unsigned LEVELS = $clog2(LEAVES);
  localparam int unsigned RANK_W = LEVELS;
  localparam int unsigned NODE_W = LEVELS + 1;
  localparam int unsigned NODES  = 2 * LEAVES;
  localparam int unsigned LVL_W  = $clog2(LEVELS + 1);
  localparam int unsigned SIB_W  = $clog2(LEVELS);

  // Payload widths.
  localparam int unsigned LEN_W = 11;
  localparam int unsigned CNT_W = 30;

  localparam logic [CNT_W-1:0] CNT_MOD = CNT_W'(1000000007);

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
  } pair_t;

  // Sum of two counts that are both below the modulus.
  function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, CNT_MOD}) begin
      s = s - {1'b0, CNT_MOD};
    end
    return s[CNT_W-1:0];
  endfunction

  // The longer length wins; equal lengths add their counts.
  function automatic pair_t merge(input pair_t a, input pair_t b);
    pair_t r;
    r = a;
    if (a.len < b.len) begin
      r = b;
    end else if (a.len == b.len) begin
      r.cnt = add_mod(a.cnt, b.cnt);
    end
    return r;
  endfunction

endpackage

>>> sv/lis_length_and_count_top.sv
// Longest strictly increasing subsequence counter over a stream of ranks.
//
// Input channel: item_valid / item_ready with a 10-bit rank per transaction.
// Output channel: result_valid / result_ready carrying end_length, end_count
// (the longest subsequences ending at this item) and best_length, best_count
// (the longest over all items so far). Counts are modulo 1000000007.
//
// The state is a 2048-entry segment tree in one single-port-write,
// registered-read memory. Each transaction reads the leaf and the ten
// siblings along its leaf-to-root path, forms the new pair, writes the leaf
// and its ten ancestors and loads the output register. A new item is taken
// only once the previous one has finished and the block is back in idle.
//
// After reset the block walks the memory once to clear all 2048 entries,
// with item_ready low. A result waits in the output register while the
// receiver stalls; the next item may be accepted and processed meanwhile,
// and it holds in its final state until the output register is free.
`timescale 1ns / 1ps
`include "lis_length_and_count_top_defines.svh"

module lis_length_and_count_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [lis_pkg::RANK_W-1:0] rank,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [lis_pkg::LEN_W-1:0]  end_length,
  output logic [lis_pkg::CNT_W-1:0]  end_count,
  output logic [lis_pkg::LEN_W-1:0]  best_length,
  output logic [lis_pkg::CNT_W-1:0]  best_count
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_CALC  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  // Control registers.
  logic [lis_pkg::NODE_W-1:0] clr_idx;
  logic [lis_pkg::LVL_W-1:0]  rd_cnt;
  logic                       rd_pend;
  logic [lis_pkg::LVL_W-1:0]  rd_k;
  logic [lis_pkg::LVL_W-1:0]  wr_cnt;

  // Payload registers.
  logic [lis_pkg::NODE_W-1:0] path;
  lis_pkg::pair_t             acc;
  lis_pkg::pair_t             leaf;
  lis_pkg::pair_t             p;
  lis_pkg::pair_t             cur;
  lis_pkg::pair_t             sib [lis_pkg::LEVELS];

  // Tree memory.
  lis_pkg::pair_t             mem [lis_pkg::NODES];
  lis_pkg::pair_t             mem_rdata;
  logic                       mem_we;
  logic [lis_pkg::NODE_W-1:0] mem_waddr;
  lis_pkg::pair_t             mem_wdata;
  logic [lis_pkg::NODE_W-1:0] mem_raddr;

  logic [lis_pkg::SIB_W-1:0]  rd_sib_idx;
  logic [lis_pkg::SIB_W-1:0]  wr_sib_idx;
  logic [lis_pkg::LVL_W-1:0]  rd_lvl;
  lis_pkg::pair_t             wr_val;
  logic [lis_pkg::NODE_W-1:0] wr_addr;
  logic                       out_free;

  assign item_ready = (state == S_IDLE);
  assign out_free   = !result_valid || result_ready;

  // Read address: the leaf first, then the sibling at each level.
  always_comb begin
    rd_lvl = (rd_cnt == '0) ? '0 : rd_cnt - 1'b1;
    if (rd_cnt == '0) begin
      mem_raddr = path;
    end else begin
      mem_raddr = lis_pkg::NODE_W'(path >> rd_lvl) ^ lis_pkg::NODE_W'(1);
    end
  end

  // Returned data at level rd_k - 1 fills sibling slot rd_k - 1.
  assign rd_sib_idx = (rd_k == '0) ? '0 : lis_pkg::SIB_W'(rd_k - 1'b1);
  assign wr_sib_idx = (wr_cnt == '0) ? '0 : lis_pkg::SIB_W'(wr_cnt - 1'b1);

  // Update walk: merged leaf first, then each parent from child and sibling.
  always_comb begin
    wr_addr = lis_pkg::NODE_W'(path >> wr_cnt);
    if (wr_cnt == '0) begin
      wr_val = lis_pkg::merge(leaf, p);
    end else begin
      wr_val = lis_pkg::merge(cur, sib[wr_sib_idx]);
    end
  end

  // Memory write port is shared by the clearing pass and the update walk.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = wr_val;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      S_WRITE: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Control state machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      rd_cnt       <= '0;
      rd_pend      <= 1'b0;
      rd_k         <= '0;
      wr_cnt       <= '0;
      result_valid <= 1'b0;
    end else begin
      // The output register fills from a finished item or empties on acceptance.
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            state  <= S_READ;
            rd_cnt <= '0;
          end
        end
        S_READ: begin
          rd_pend <= (rd_cnt <= lis_pkg::LVL_W'(lis_pkg::LEVELS));
          rd_k    <= rd_cnt;
          if (rd_cnt <= lis_pkg::LVL_W'(lis_pkg::LEVELS)) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (rd_pend && rd_k == lis_pkg::LVL_W'(lis_pkg::LEVELS)) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          state  <= S_WRITE;
          wr_cnt <= '0;
        end
        S_WRITE: begin
          wr_cnt <= wr_cnt + 1'b1;
          if (wr_cnt == lis_pkg::LVL_W'(lis_pkg::LEVELS)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      path <= {1'b1, rank};
      acc  <= '0;
    end
    // Capture read data; left siblings of the path cover the ranks below.
    if (state == S_READ && rd_pend) begin
      if (rd_k == '0) begin
        leaf <= mem_rdata;
      end else begin
        sib[rd_sib_idx] <= mem_rdata;
        if (path[rd_sib_idx]) begin
          acc <= lis_pkg::merge(acc, mem_rdata);
        end
      end
    end
    // New pair: one longer than the best below, count one if none exists.
    if (state == S_CALC) begin
      p.len <= acc.len + 1'b1;
      p.cnt <= (acc.len == '0) ? lis_pkg::CNT_W'(1) : acc.cnt;
    end
    if (state == S_WRITE) begin
      cur <= wr_val;
    end
    if (state == S_DONE && out_free) begin
      end_length  <= p.len;
      end_count   <= p.cnt;
      best_length <= cur.len;
      best_count  <= cur.cnt;
    end
  end

  // Checks.
  `LIS_ASSERT(a_accept_starts_read, clk, rst,
    (item_valid && item_ready) |=> (state == S_READ), "accepted item did not start a read")
  `LIS_ASSERT(a_no_node_zero, clk, rst,
    (state == S_WRITE) |-> (wr_addr != '0), "update walk wrote the unused node")
  `LIS_ASSERT(a_count_in_range, clk, rst,
    result_valid |-> (end_count < lis_pkg::CNT_MOD && best_count < lis_pkg::CNT_MOD),
    "result count not reduced")
  `LIS_ASSERT(a_best_covers_end, clk, rst,
    result_valid |-> (best_length >= end_length && end_length != '0),
    "best length below this item's length")
  `LIS_ASSERT_ALWAYS(a_rd_only_in_read, clk,
    rd_pend |-> (state == S_READ || state == S_CALC), "read data pending outside read")

endmodule
